/* rtl/ssi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg
// Widths and constants of the segment stamp interpolator.
// ----------------------------------------------------------------------------
package ssi_pkg;

	localparam int COORD_W       = 20;              // Q15.4 coordinate
	localparam int SPACING_W     = 12;              // Q8.4 spacing
	localparam int DIST_W        = COORD_W + 1;     // magnitude of a difference, length
	localparam int RAD_W         = 2 * DIST_W;      // dx^2 + dy^2
	localparam int SUB_W         = DIST_W + 4;      // shared subtractor
	localparam int IN_W          = 4 * COORD_W;
	localparam int OUT_W         = 2 * COORD_W;
	localparam logic [SPACING_W-1:0] SPACING_RESET = 12'd32;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [DIST_W-1:0]  mag_t;

endpackage

/* rtl/segment_stamp_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_stamp_interpolator
// Evenly spaced brush stamps along a Q15.4 segment, then the end point.
// ----------------------------------------------------------------------------
// One segment request is taken, then s_tready stays low until its last point
// (m_tlast) has been taken. A single 21x21 multiplier and one 25-bit
// compare/subtract unit do all the arithmetic under a sequencer: square and
// add, square root, then divide the length by the spacing into a PW-bit
// quotient (PW = 21 + clog2(MAX_STEPS+1) + 12, 39 by default), then per stamp
// two multiply-and-divide passes and an output state. An output stall holds
// the sequencer in the output state.
// ----------------------------------------------------------------------------
module segment_stamp_interpolator #(
	parameter int MAX_STEPS = 63
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// stamp spacing write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ssi_pkg::SPACING_W-1:0] cfg_data,
	// segment in
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ssi_pkg::IN_W-1:0]  s_tdata,   // start_x, start_y, end_x, end_y
	// points out
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [ssi_pkg::OUT_W-1:0] m_tdata,   // point_x, point_y
	output logic                      m_tlast,   // is_last
	output logic                      m_tuser    // count_clamped
);
	import ssi_pkg::*;

	localparam int CW    = $clog2(MAX_STEPS + 1);
	localparam int AW    = CW + SPACING_W;
	localparam int PW    = DIST_W + AW;
	localparam int CNT_W = $clog2(PW);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQX, ST_SQY, ST_SUM, ST_SQRT, ST_DIVN, ST_MUL, ST_DIVP, ST_EMIT
	} state_t;

	state_t               state_q;
	logic [SPACING_W-1:0] spacing_q;
	coord_t               sx_q, sy_q, ex_q, ey_q;
	mag_t                 adx_q, ady_q, dist_q;
	logic                 negx_q, negy_q;
	logic [RAD_W-1:0]     prod_q, rad_q;
	logic [DIST_W-1:0]    root_q;
	logic [SUB_W-3:0]     srem_q;
	logic [PW-1:0]        num_q;
	logic [DIST_W:0]      drem_q;
	mag_t                 div_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CW-1:0]        n_q, i_q;
	logic [AW-1:0]        along_q;
	logic                 axis_q, clamp_q, last_q;
	coord_t               px_q, ox_q, oy_q;

	// spacing zero acts as one
	logic [SPACING_W-1:0] sp;
	assign sp = (spacing_q == '0) ? SPACING_W'(1) : spacing_q;

	// input split and differences
	coord_t in_sx, in_sy, in_ex, in_ey;
	mag_t   dx, dy;
	assign in_sx = s_tdata[COORD_W-1:0];
	assign in_sy = s_tdata[2*COORD_W-1:COORD_W];
	assign in_ex = s_tdata[3*COORD_W-1:2*COORD_W];
	assign in_ey = s_tdata[4*COORD_W-1:3*COORD_W];
	assign dx = {in_ex[COORD_W-1], in_ex} - {in_sx[COORD_W-1], in_sx};
	assign dy = {in_ey[COORD_W-1], in_ey} - {in_sy[COORD_W-1], in_sy};

	// shared multiplier
	mag_t             mul_a, mul_b;
	logic [RAD_W-1:0] mul_res;
	always_comb begin
		unique case (state_q)
			ST_SQX:  begin mul_a = adx_q; mul_b = adx_q; end
			ST_SQY:  begin mul_a = ady_q; mul_b = ady_q; end
			default: begin
				mul_a = axis_q ? ady_q : adx_q;
				mul_b = DIST_W'(along_q);
			end
		endcase
	end
	assign mul_res = mul_a * mul_b;

	// shared compare/subtract: square root trial or division step
	logic [SUB_W-1:0] sub_a, sub_b, sub_r;
	logic             sub_ok;
	always_comb begin
		if (state_q == ST_SQRT) begin
			sub_a = {srem_q, rad_q[RAD_W-1 -: 2]};
			sub_b = SUB_W'({root_q, 2'b01});
		end else begin
			sub_a = SUB_W'({drem_q[DIST_W-1:0], num_q[PW-1]});
			sub_b = SUB_W'(div_q);
		end
	end
	assign sub_r  = sub_a - sub_b;
	assign sub_ok = (sub_a >= sub_b);

	logic [PW-1:0] quot;
	mag_t          root_nx;
	coord_t        qc;
	assign quot    = {num_q[PW-2:0], sub_ok};
	assign root_nx = {root_q[DIST_W-2:0], sub_ok};
	assign qc      = quot[COORD_W-1:0];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = (state_q == ST_EMIT);
	assign m_tdata   = {oy_q, ox_q};
	assign m_tlast   = last_q;
	assign m_tuser   = clamp_q;

	// hold the spacing register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RESET;
		end else if (cfg_valid && cfg_ready) begin
			spacing_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
			clamp_q <= 1'b0;
			cnt_q   <= '0;
			axis_q  <= 1'b0;
			i_q     <= '0;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						sx_q    <= in_sx;
						sy_q    <= in_sy;
						ex_q    <= in_ex;
						ey_q    <= in_ey;
						negx_q  <= dx[DIST_W-1];
						negy_q  <= dy[DIST_W-1];
						adx_q   <= dx[DIST_W-1] ? -dx : dx;
						ady_q   <= dy[DIST_W-1] ? -dy : dy;
						state_q <= ST_SQX;
					end
				end
				ST_SQX: begin
					prod_q  <= mul_res;
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					rad_q   <= prod_q;
					prod_q  <= mul_res;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					rad_q   <= rad_q + prod_q;
					root_q  <= '0;
					srem_q  <= '0;
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				// one root bit a cycle
				ST_SQRT: begin
					rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
					srem_q <= sub_ok ? sub_r[SUB_W-3:0] : sub_a[SUB_W-3:0];
					root_q <= root_nx;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIST_W - 1)) begin
						dist_q  <= root_nx;
						num_q   <= PW'(root_nx);
						div_q   <= DIST_W'(sp);
						drem_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIVN;
					end
				end
				// one quotient bit a cycle: length over spacing
				ST_DIVN: begin
					num_q  <= quot;
					drem_q <= sub_ok ? sub_r[DIST_W:0] : sub_a[DIST_W:0];
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(PW - 1)) begin
						i_q     <= CW'(1);
						along_q <= AW'(sp);
						axis_q  <= 1'b0;
						if (quot > PW'(MAX_STEPS)) begin
							n_q     <= CW'(MAX_STEPS);
							clamp_q <= 1'b1;
						end else begin
							n_q     <= quot[CW-1:0];
							clamp_q <= 1'b0;
						end
						if (quot == '0) begin
							ox_q    <= ex_q;
							oy_q    <= ey_q;
							last_q  <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					num_q   <= mul_res[PW-1:0];
					div_q   <= dist_q;
					drem_q  <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIVP;
				end
				// one quotient bit a cycle: offset along the axis
				ST_DIVP: begin
					num_q  <= quot;
					drem_q <= sub_ok ? sub_r[DIST_W:0] : sub_a[DIST_W:0];
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(PW - 1)) begin
						if (!axis_q) begin
							px_q    <= negx_q ? sx_q - qc : sx_q + qc;
							axis_q  <= 1'b1;
							state_q <= ST_MUL;
						end else begin
							ox_q    <= px_q;
							oy_q    <= negy_q ? sy_q - qc : sy_q + qc;
							last_q  <= 1'b0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						if (last_q) begin
							state_q <= ST_IDLE;
						end else if (i_q == n_q) begin
							ox_q   <= ex_q;
							oy_q   <= ey_q;
							last_q <= 1'b1;
						end else begin
							i_q     <= i_q + 1'b1;
							along_q <= along_q + AW'(sp);
							axis_q  <= 1'b0;
							state_q <= ST_MUL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the stamp index never passes the count
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (i_q <= n_q))
		else $error("stamp index beyond count");

	// a point on offer blocks new segments
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("ready while a point is pending");

	// an accepted segment makes the block busy
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !m_tvalid)
		else $error("segment not taken into work");

	// the end point closes the run
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready)
		else $error("no return to idle after end point");

endmodule
